// ----- src/fpsm_pkg.sv -----
package fpsm_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 1024;

	localparam int SAMPLE_W    = 32;
	localparam int COEF_W      = 32;
	localparam int DIM_W       = 11;
	localparam int INDEX_W     = 20;
	localparam int COUNT_W     = 21;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int ROW_W       = $clog2(MAX_HEIGHT) + 1;

	localparam int WIN_DEPTH   = 2 * MAX_WIDTH;
	localparam int WIN_ADDR_W  = $clog2(WIN_DEPTH);
	localparam int DIST_W      = WIN_ADDR_W + 1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_COEF_CENTER     = 3'd0,
		REG_COEF_HORIZONTAL = 3'd1,
		REG_COEF_VERTICAL   = 3'd2,
		REG_GRID_WIDTH      = 3'd3,
		REG_GRID_HEIGHT     = 3'd4,
		REG_RANGE_FIRST     = 3'd5,
		REG_RANGE_LAST      = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] coef_center;
		logic signed [COEF_W-1:0] coef_horizontal;
		logic signed [COEF_W-1:0] coef_vertical;
		logic [DIM_W-1:0]         grid_width;
		logic [DIM_W-1:0]         grid_height;
		logic [INDEX_W-1:0]       range_first;
		logic [INDEX_W-1:0]       range_last;
	} cfg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] center;
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
		logic signed [SAMPLE_W-1:0] up;
		logic signed [SAMPLE_W-1:0] down;
		logic [INDEX_W-1:0]         point_index;
		logic                       last;
	} job_t;

endpackage

// ----- src/fpsm_if.sv -----
interface fpsm_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [fpsm_pkg::SAMPLE_W-1:0] sample;
	logic                                 flush;

	modport source (output valid, output sample, output flush, input ready);
	modport sink (input valid, input sample, input flush, output ready);
endinterface

interface fpsm_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [fpsm_pkg::SAMPLE_W-1:0] result;
	logic [fpsm_pkg::INDEX_W-1:0]         point_index;
	logic                                 last;

	modport source (output valid, output result, output point_index, output last, input ready);
	modport sink (input valid, input result, input point_index, input last, output ready);
endinterface

// ----- src/five_point_stencil_matvec.sv -----
// five-point stencil product over a streamed grid
// stream_in takes one grid value per transfer in raster order (row 0 first),
// with flush set on drain items; after the grid, grid_width flush items push
// out the last row. stream_out gives one transfer per point inside
// [range_first, range_last], carrying the q16.16 result, its raster index and
// last on the final point of the range.
// the result of a point is ready once the item holding its down neighbour,
// grid_width items later, has been taken: it then passes the front-end
// register, the queue, back-end stages s1, s2, s3 and the output register.
// throughput is one item per cycle while stream_out takes results, set by the
// line buffer, which takes one write and four reads per transfer, and by the
// three multipliers of the back end; a four-entry queue sits between the
// window front end and the multiply pipeline.
// configuration goes through cfg_we / cfg_index / cfg_data; the user must
// write it only while the block is idle, which the block does not enforce.
// reset clears frame position, queue and pipeline, restores the register
// defaults, and the window reads as zero until filled. when stream_out is
// stalled, pipeline and queue fill, then stream_in drops ready; nothing lost.
module five_point_stencil_matvec (
	input  logic                               clk,
	input  logic                               arst_n,
	fpsm_in_if.sink                            stream_in,
	fpsm_out_if.source                         stream_out,
	input  logic                               cfg_we,
	input  logic [fpsm_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [fpsm_pkg::CFG_DATA_W-1:0]    cfg_data
);

	fpsm_pkg::cfg_t                         cfg_q;
	logic                                   push_valid;
	fpsm_pkg::job_t                         push_job;
	logic                                   pop;
	logic                                   q_valid;
	fpsm_pkg::job_t                         q_head;
	logic [fpsm_pkg::QUEUE_CNT_W-1:0]       q_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coef_center     <= 32'sh0001_0000;
			cfg_q.coef_horizontal <= '0;
			cfg_q.coef_vertical   <= '0;
			cfg_q.grid_width      <= fpsm_pkg::DIM_W'(16);
			cfg_q.grid_height     <= fpsm_pkg::DIM_W'(16);
			cfg_q.range_first     <= '0;
			cfg_q.range_last      <= fpsm_pkg::INDEX_W'(255);
		end else if (cfg_we) begin
			unique case (fpsm_pkg::cfg_reg_t'(cfg_index))
				fpsm_pkg::REG_COEF_CENTER: begin
					cfg_q.coef_center <= cfg_data;
				end
				fpsm_pkg::REG_COEF_HORIZONTAL: begin
					cfg_q.coef_horizontal <= cfg_data;
				end
				fpsm_pkg::REG_COEF_VERTICAL: begin
					cfg_q.coef_vertical <= cfg_data;
				end
				fpsm_pkg::REG_GRID_WIDTH: begin
					cfg_q.grid_width <= cfg_data[fpsm_pkg::DIM_W-1:0];
				end
				fpsm_pkg::REG_GRID_HEIGHT: begin
					cfg_q.grid_height <= cfg_data[fpsm_pkg::DIM_W-1:0];
				end
				fpsm_pkg::REG_RANGE_FIRST: begin
					cfg_q.range_first <= cfg_data[fpsm_pkg::INDEX_W-1:0];
				end
				fpsm_pkg::REG_RANGE_LAST: begin
					cfg_q.range_last <= cfg_data[fpsm_pkg::INDEX_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	fpsm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.stream_in  (stream_in),
		.cfg        (cfg_q),
		.q_count    (q_count),
		.push_valid (push_valid),
		.push_job   (push_job)
	);

	fpsm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push_valid),
		.push_job   (push_job),
		.pop        (pop),
		.head_valid (q_valid),
		.head       (q_head),
		.count      (q_count)
	);

	fpsm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_valid    (q_valid),
		.q_head     (q_head),
		.pop        (pop),
		.stream_out (stream_out)
	);

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> (q_count < fpsm_pkg::QUEUE_CNT_W'(fpsm_pkg::QUEUE_DEPTH)))
		else $error("queue written while full");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(q_count == $past(q_count)) || (q_count == $past(q_count) + fpsm_pkg::QUEUE_CNT_W'(1)) ||
		(q_count + fpsm_pkg::QUEUE_CNT_W'(1) == $past(q_count)))
		else $error("queue count jumped");

	a_stall_reason: assert property (@(posedge clk) disable iff (!arst_n)
		!stream_in.ready |-> (q_count >= fpsm_pkg::QUEUE_CNT_W'(fpsm_pkg::QUEUE_DEPTH - 1)))
		else $error("input stalled with room in queue");
`endif

endmodule

// ----- src/fpsm_queue.sv -----
module fpsm_queue (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	input  fpsm_pkg::job_t                     push_job,
	input  logic                               pop,
	output logic                               head_valid,
	output fpsm_pkg::job_t                     head,
	output logic [fpsm_pkg::QUEUE_CNT_W-1:0]   count
);

	fpsm_pkg::job_t                         entries_q [fpsm_pkg::QUEUE_DEPTH];
	logic [fpsm_pkg::QUEUE_PTR_W-1:0]       wr_q;
	logic [fpsm_pkg::QUEUE_PTR_W-1:0]       rd_q;
	logic [fpsm_pkg::QUEUE_CNT_W-1:0]       count_q;

	assign head_valid = (count_q != '0);
	assign head       = entries_q[rd_q];
	assign count      = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + fpsm_pkg::QUEUE_PTR_W'(1);
			if (pop)
				rd_q <= rd_q + fpsm_pkg::QUEUE_PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + fpsm_pkg::QUEUE_CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - fpsm_pkg::QUEUE_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_q] <= push_job;
	end

endmodule

// ----- src/fpsm_front.sv -----
module fpsm_front (
	input  logic                               clk,
	input  logic                               arst_n,
	fpsm_in_if.sink                            stream_in,
	input  fpsm_pkg::cfg_t                     cfg,
	input  logic [fpsm_pkg::QUEUE_CNT_W-1:0]   q_count,
	output logic                               push_valid,
	output fpsm_pkg::job_t                     push_job
);

	localparam int DIM_W  = fpsm_pkg::DIM_W;
	localparam int CNT_W  = fpsm_pkg::COUNT_W;
	localparam int COL_W  = fpsm_pkg::COL_W;
	localparam int ROW_W  = fpsm_pkg::ROW_W;
	localparam int AW     = fpsm_pkg::WIN_ADDR_W;
	localparam int DW     = fpsm_pkg::DIST_W;
	localparam int SW     = fpsm_pkg::SAMPLE_W;
	localparam int OCC_W  = fpsm_pkg::QUEUE_CNT_W + 1;

	// frame position
	logic [CNT_W-1:0]  k_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;

	// line buffer, two copies for four reads a transfer
	logic signed [SW-1:0] win_a_q [fpsm_pkg::WIN_DEPTH];
	logic signed [SW-1:0] win_b_q [fpsm_pkg::WIN_DEPTH];
	logic [AW-1:0]        wp_q;
	logic [DW-1:0]        fill_q;

	logic                 valid_s1;
	logic signed [SW-1:0] center_s1;
	logic signed [SW-1:0] left_s1;
	logic signed [SW-1:0] right_s1;
	logic signed [SW-1:0] up_s1;
	logic signed [SW-1:0] down_s1;
	logic                 use_center_s1;
	logic                 use_left_s1;
	logic                 use_right_s1;
	logic                 use_up_s1;
	logic                 use_down_s1;
	logic [fpsm_pkg::INDEX_W-1:0] index_s1;
	logic                 last_s1;

	logic [DIM_W-1:0]  w_eff;
	logic [DIM_W-1:0]  h_eff;
	logic [CNT_W-1:0]  n;
	logic [CNT_W-1:0]  n_m1;
	logic [CNT_W-1:0]  p;
	logic [CNT_W-1:0]  stop;
	logic              warm;
	logic              beyond;
	logic              emit;
	logic              has_left;
	logic              has_right;
	logic              has_up;
	logic              has_down;
	logic              accept;
	logic [OCC_W-1:0]  occ;
	logic signed [SW-1:0] wval;
	logic [DW-1:0]     d_center;
	logic [DW-1:0]     d_right;
	logic [DW-1:0]     d_left;
	logic [DW-1:0]     d_up;
	logic [AW-1:0]     a_center;
	logic [AW-1:0]     a_right;
	logic [AW-1:0]     a_left;
	logic [AW-1:0]     a_up;
	logic [ROW_W-1:0]  row_inc;

	always_comb begin
		w_eff = cfg.grid_width;
		if (cfg.grid_width == '0)
			w_eff = DIM_W'(1);
		else if (cfg.grid_width > DIM_W'(fpsm_pkg::MAX_WIDTH))
			w_eff = DIM_W'(fpsm_pkg::MAX_WIDTH);
		h_eff = cfg.grid_height;
		if (cfg.grid_height == '0)
			h_eff = DIM_W'(1);
		else if (cfg.grid_height > DIM_W'(fpsm_pkg::MAX_HEIGHT))
			h_eff = DIM_W'(fpsm_pkg::MAX_HEIGHT);
	end

	assign n      = CNT_W'(w_eff) * CNT_W'(h_eff);
	assign n_m1   = n - CNT_W'(1);
	assign warm   = (k_q < CNT_W'(w_eff));
	assign p      = k_q - CNT_W'(w_eff);
	assign beyond = (p >= n);
	assign stop   = (CNT_W'(cfg.range_last) < n_m1) ? CNT_W'(cfg.range_last) : n_m1;
	assign emit   = !warm && !beyond && (p >= CNT_W'(cfg.range_first)) && (p <= stop);

	assign has_left  = (col_q != '0);
	assign has_right = ((DIM_W'(col_q) + DIM_W'(1)) < w_eff);
	assign has_up    = (row_q != '0);
	assign has_down  = ((row_q + ROW_W'(1)) < ROW_W'(h_eff));
	assign row_inc   = (row_q == ROW_W'(fpsm_pkg::MAX_HEIGHT)) ? row_q : row_q + ROW_W'(1);

	assign occ             = OCC_W'(q_count) + OCC_W'(valid_s1);
	assign stream_in.ready = (occ < OCC_W'(fpsm_pkg::QUEUE_DEPTH));
	assign accept          = stream_in.valid && stream_in.ready;

	assign wval     = stream_in.flush ? '0 : stream_in.sample;
	assign d_center = DW'(w_eff);
	assign d_right  = d_center - DW'(1);
	assign d_left   = d_center + DW'(1);
	assign d_up     = {d_center[DW-2:0], 1'b0};
	assign a_center = wp_q - d_center[AW-1:0];
	assign a_right  = wp_q - d_right[AW-1:0];
	assign a_left   = wp_q - d_left[AW-1:0];
	assign a_up     = wp_q - d_up[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= '0;
			col_q    <= '0;
			row_q    <= '0;
			wp_q     <= '0;
			fill_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && emit;
			if (accept) begin
				wp_q <= wp_q + AW'(1);
				if (fill_q != DW'(fpsm_pkg::WIN_DEPTH))
					fill_q <= fill_q + DW'(1);
				if (warm) begin
					k_q <= k_q + CNT_W'(1);
				end else if (beyond || p == n_m1) begin
					k_q   <= '0;
					col_q <= '0;
					row_q <= '0;
				end else begin
					k_q <= k_q + CNT_W'(1);
					if (has_right) begin
						col_q <= col_q + COL_W'(1);
					end else begin
						col_q <= '0;
						row_q <= row_inc;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			win_a_q[wp_q]  <= wval;
			win_b_q[wp_q]  <= wval;
			center_s1      <= win_a_q[a_center];
			right_s1       <= win_a_q[a_right];
			left_s1        <= win_b_q[a_left];
			up_s1          <= win_b_q[a_up];
			down_s1        <= wval;
			use_center_s1  <= (d_center <= fill_q);
			use_right_s1   <= has_right && (d_right <= fill_q);
			use_left_s1    <= has_left && (d_left <= fill_q);
			use_up_s1      <= has_up && (d_up <= fill_q);
			use_down_s1    <= has_down;
			index_s1       <= p[fpsm_pkg::INDEX_W-1:0];
			last_s1        <= (p == stop);
		end
	end

	assign push_valid = valid_s1;

	always_comb begin
		push_job.center      = use_center_s1 ? center_s1 : '0;
		push_job.left        = use_left_s1 ? left_s1 : '0;
		push_job.right       = use_right_s1 ? right_s1 : '0;
		push_job.up          = use_up_s1 ? up_s1 : '0;
		push_job.down        = use_down_s1 ? down_s1 : '0;
		push_job.point_index = index_s1;
		push_job.last        = last_s1;
	end

endmodule

// ----- src/fpsm_back.sv -----
module fpsm_back (
	input  logic           clk,
	input  logic           arst_n,
	input  fpsm_pkg::cfg_t cfg,
	input  logic           q_valid,
	input  fpsm_pkg::job_t q_head,
	output logic           pop,
	fpsm_out_if.source     stream_out
);

	localparam int SW = fpsm_pkg::SAMPLE_W;
	localparam int IW = fpsm_pkg::INDEX_W;
	localparam int TW = 67;

	logic                  v_s1;
	logic                  v_s2;
	logic                  v_s3;
	logic                  out_valid_q;

	logic signed [SW-1:0]  center_s1;
	logic signed [SW:0]    hsum_s1;
	logic signed [SW:0]    vsum_s1;
	logic [IW-1:0]         index_s1;
	logic                  last_s1;

	logic signed [2*SW-1:0] pc_s2;
	logic signed [2*SW:0]   ph_s2;
	logic signed [2*SW:0]   pv_s2;
	logic [IW-1:0]          index_s2;
	logic                   last_s2;

	logic signed [TW-1:0]   total_s3;
	logic [IW-1:0]          index_s3;
	logic                   last_s3;

	logic signed [SW-1:0]   result_q;
	logic [IW-1:0]          index_q;
	logic                   last_q;

	logic                   adv_out;
	logic                   adv3;
	logic                   adv2;
	logic                   adv1;
	logic signed [TW-1:0]   rnd;
	logic                   fits;
	logic signed [SW-1:0]   sat;

	assign adv_out = !out_valid_q || stream_out.ready;
	assign adv3    = !v_s3 || adv_out;
	assign adv2    = !v_s2 || adv3;
	assign adv1    = !v_s1 || adv2;
	assign pop     = q_valid && adv1;

	// round half up to q16.16, then clamp to 32 bits
	assign rnd  = total_s3 + TW'(32768);
	assign fits = (rnd[TW-1:2*SW-17] == '0) || (rnd[TW-1:2*SW-17] == '1);
	assign sat  = fits ? rnd[2*SW-17:16] :
	              (rnd[TW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv1)
				v_s1 <= q_valid;
			if (adv2)
				v_s2 <= v_s1;
			if (adv3)
				v_s3 <= v_s2;
			if (adv_out)
				out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			center_s1 <= q_head.center;
			hsum_s1   <= {q_head.left[SW-1], q_head.left} + {q_head.right[SW-1], q_head.right};
			vsum_s1   <= {q_head.up[SW-1], q_head.up} + {q_head.down[SW-1], q_head.down};
			index_s1  <= q_head.point_index;
			last_s1   <= q_head.last;
		end
		if (adv2) begin
			pc_s2    <= $signed(cfg.coef_center) * center_s1;
			ph_s2    <= $signed(cfg.coef_horizontal) * hsum_s1;
			pv_s2    <= $signed(cfg.coef_vertical) * vsum_s1;
			index_s2 <= index_s1;
			last_s2  <= last_s1;
		end
		if (adv3) begin
			total_s3 <= {{(TW-2*SW){pc_s2[2*SW-1]}}, pc_s2}
			          + {{(TW-2*SW-1){ph_s2[2*SW]}}, ph_s2}
			          + {{(TW-2*SW-1){pv_s2[2*SW]}}, pv_s2};
			index_s3 <= index_s2;
			last_s3  <= last_s2;
		end
		if (adv_out) begin
			result_q <= sat;
			index_q  <= index_s3;
			last_q   <= last_s3;
		end
	end

	assign stream_out.valid       = out_valid_q;
	assign stream_out.result      = result_q;
	assign stream_out.point_index = index_q;
	assign stream_out.last        = last_q;

endmodule

// ----- bench/five_point_stencil_matvec_tb.sv -----
`timescale 1ns / 100ps

module five_point_stencil_matvec_tb;

	localparam int WINDOW_LEN   = 2 * fpsm_pkg::MAX_WIDTH + 1;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_ITEMS = 560;

	typedef struct packed {
		logic signed [fpsm_pkg::SAMPLE_W-1:0] value;
		logic [fpsm_pkg::INDEX_W-1:0]         index;
		logic                                 last;
	} point_result_t;

	typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		fpsm_pkg::cfg_reg_t target;
		logic [31:0]        data;
		logic               flush;
		bit                 typed;
		point_result_t      want;
	} table_row_t;

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_we;
	logic [fpsm_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [fpsm_pkg::CFG_DATA_W-1:0]  cfg_data;

	fpsm_in_if  grid_in ();
	fpsm_out_if points_out ();

	five_point_stencil_matvec DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.stream_in  (grid_in),
		.stream_out (points_out),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// register copy, reset values
	logic signed [fpsm_pkg::COEF_W-1:0] k_center     = 32'sd65536;
	logic signed [fpsm_pkg::COEF_W-1:0] k_horizontal = '0;
	logic signed [fpsm_pkg::COEF_W-1:0] k_vertical   = '0;
	logic [fpsm_pkg::DIM_W-1:0]         width_reg    = 11'd16;
	logic [fpsm_pkg::DIM_W-1:0]         height_reg   = 11'd16;
	logic [fpsm_pkg::INDEX_W-1:0]       first_reg    = '0;
	logic [fpsm_pkg::INDEX_W-1:0]       last_reg     = 20'd255;

	// stencil state
	longint      grid_window[$];
	int unsigned frame_count = 0;
	int unsigned next_col    = 0;
	int unsigned next_row    = 0;

	point_result_t expected_points[$];
	table_row_t    directed_rows[$];
	int unsigned   mismatches  = 0;
	int unsigned   fed_items   = 0;
	int unsigned   cycle_count = 0;
	bit            steady      = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** five_point_stencil_matvec: FAILED **");
			$finish;
		end
	end

	function automatic int unsigned eff_width();
		int unsigned w;
		w = width_reg;
		if (w < 1) w = 1;
		if (w > fpsm_pkg::MAX_WIDTH) w = fpsm_pkg::MAX_WIDTH;
		return w;
	endfunction

	function automatic int unsigned eff_height();
		int unsigned h;
		h = height_reg;
		if (h < 1) h = 1;
		if (h > fpsm_pkg::MAX_HEIGHT) h = fpsm_pkg::MAX_HEIGHT;
		return h;
	endfunction

	function automatic int unsigned frame_len();
		return eff_width() * eff_height() + eff_width();
	endfunction

	function automatic int draw_wait();
		return steady ? 0 : $urandom_range(0, 4);
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0;
			3, 4: return 32'($urandom_range(0, 262143)) - 32'd131072;
			default: return $urandom;
		endcase
	endfunction

	task automatic stencil_step(input logic signed [31:0] s, input logic f,
			output bit hit, output point_result_t r);
		int unsigned w, h, n, k, p, col, row, stop;
		logic signed [71:0] acc, v, lim;
		hit = 0;
		r = '0;
		w = eff_width();
		h = eff_height();
		n = w * h;
		k = frame_count;
		grid_window.push_front(f ? 64'sd0 : longint'(s));
		void'(grid_window.pop_back());
		if (k < w) begin
			frame_count = k + 1;
			return;
		end
		p = k - w;
		if (p >= n) begin
			frame_count = 0;
			next_col = 0;
			next_row = 0;
			return;
		end
		col = next_col;
		row = next_row;
		acc = '0;
		acc += k_center * grid_window[w];
		if (col > 0) acc += k_horizontal * grid_window[w + 1];
		if (col + 1 < w) acc += k_horizontal * grid_window[w - 1];
		if (row > 0) acc += k_vertical * grid_window[2 * w];
		if (row + 1 < h) acc += k_vertical * grid_window[0];
		if (col + 1 >= w) begin
			next_col = 0;
			next_row = row + 1;
		end else begin
			next_col = col + 1;
		end
		if (p + 1 >= n) begin
			frame_count = 0;
			next_col = 0;
			next_row = 0;
		end else begin
			frame_count = k + 1;
		end
		stop = (last_reg < n - 1) ? last_reg : n - 1;
		if (p >= first_reg && p <= stop) begin
			hit = 1;
			// round half up, then saturate
			v = acc + 72'sd32768;
			lim = 72'sd1 <<< 47;
			if (v >= lim) r.value = 32'h7FFF_FFFF;
			else if (v < -lim) r.value = 32'h8000_0000;
			else r.value = v[47:16];
			r.index = p[fpsm_pkg::INDEX_W-1:0];
			r.last = (p == stop);
		end
	endtask

	task automatic transfer_in(input logic signed [31:0] s, input logic f,
			output bit hit, output point_result_t r);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			grid_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		grid_in.valid <= 1'b1;
		grid_in.sample <= s;
		grid_in.flush <= f;
		do @(posedge clk); while (!grid_in.ready);
		fed_items++;
		stencil_step(s, f, hit, r);
	endtask

	task automatic feed(input logic signed [31:0] s, input logic f);
		bit hit;
		point_result_t r;
		transfer_in(s, f, hit, r);
		if (hit) expected_points.push_back(r);
	endtask

	task automatic hold_until_drained();
		grid_in.valid <= 1'b0;
		do @(posedge clk); while (expected_points.size() != 0);
	endtask

	task automatic settle();
		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input fpsm_pkg::cfg_reg_t sel,
			input logic [fpsm_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (sel)
			fpsm_pkg::REG_COEF_CENTER:     k_center = data;
			fpsm_pkg::REG_COEF_HORIZONTAL: k_horizontal = data;
			fpsm_pkg::REG_COEF_VERTICAL:   k_vertical = data;
			fpsm_pkg::REG_GRID_WIDTH:      width_reg = data[fpsm_pkg::DIM_W-1:0];
			fpsm_pkg::REG_GRID_HEIGHT:     height_reg = data[fpsm_pkg::DIM_W-1:0];
			fpsm_pkg::REG_RANGE_FIRST:     first_reg = data[fpsm_pkg::INDEX_W-1:0];
			fpsm_pkg::REG_RANGE_LAST:      last_reg = data[fpsm_pkg::INDEX_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic setup(input logic [31:0] c, input logic [31:0] hz, input logic [31:0] vt,
			input int unsigned w, input int unsigned h,
			input int unsigned f, input int unsigned l);
		settle();
		steady = ($urandom_range(0, 3) == 0);
		write_reg(fpsm_pkg::REG_COEF_CENTER, c);
		write_reg(fpsm_pkg::REG_COEF_HORIZONTAL, hz);
		write_reg(fpsm_pkg::REG_COEF_VERTICAL, vt);
		write_reg(fpsm_pkg::REG_GRID_WIDTH, w);
		write_reg(fpsm_pkg::REG_GRID_HEIGHT, h);
		write_reg(fpsm_pkg::REG_RANGE_FIRST, f);
		write_reg(fpsm_pkg::REG_RANGE_LAST, l);
	endtask

	task automatic random_setup();
		int unsigned w, h, n, f, l;
		case ($urandom_range(0, 9))
			0: w = 0;
			1: w = $urandom_range(9, 24);
			default: w = $urandom_range(1, 8);
		endcase
		case ($urandom_range(0, 9))
			0: h = 0;
			1: h = 1;
			2: h = $urandom_range(9, 16);
			default: h = $urandom_range(2, 8);
		endcase
		n = (w < 1 ? 1 : w) * (h < 1 ? 1 : h);
		case ($urandom_range(0, 5))
			0: begin
				f = $urandom_range(0, n - 1);
				l = $urandom_range(f, n - 1);
			end
			1: begin
				// inverted range
				f = $urandom_range(1, n);
				l = f - 1;
			end
			2: begin
				f = $urandom_range(0, 20'hFFFFF);
				l = 20'hFFFFF;
			end
			3: begin
				f = 0;
				l = $urandom_range(0, 20'hFFFFF);
			end
			default: begin
				f = 0;
				l = 20'hFFFFF;
			end
		endcase
		setup(pick_value(), pick_value(), pick_value(), w, h, f, l);
	endtask

	task automatic stream_grid(input int unsigned from, input int unsigned upto);
		int unsigned n;
		n = eff_width() * eff_height();
		for (int unsigned i = from; i < upto; i++) begin
			if (i < n) feed(pick_value(), $urandom_range(0, 19) == 0);
			else feed($urandom, $urandom_range(0, 3) != 0);
			if ($urandom_range(0, 199) == 0) hold_until_drained();
		end
	endtask

	function automatic void add_write(input fpsm_pkg::cfg_reg_t sel, input logic [31:0] data);
		directed_rows.push_back('{kind: ROW_WRITE, target: sel, data: data, flush: 1'b0,
			typed: 1'b0, want: '0});
	endfunction

	function automatic void add_item(input logic [31:0] data, input logic f);
		directed_rows.push_back('{kind: ROW_ITEM, target: fpsm_pkg::REG_COEF_CENTER,
			data: data, flush: f, typed: 1'b0, want: '0});
	endfunction

	function automatic void add_point(input logic [31:0] data, input logic f,
			input logic [31:0] value, input logic [fpsm_pkg::INDEX_W-1:0] idx,
			input logic last);
		point_result_t want;
		want.value = value;
		want.index = idx;
		want.last = last;
		directed_rows.push_back('{kind: ROW_ITEM, target: fpsm_pkg::REG_COEF_CENTER,
			data: data, flush: f, typed: 1'b1, want: want});
	endfunction

	function automatic void build_directed();
		// reset coefficients, one column, two rows
		add_write(fpsm_pkg::REG_GRID_WIDTH, 32'd1);
		add_write(fpsm_pkg::REG_GRID_HEIGHT, 32'd2);
		add_item(32'h7FFF_FFFF, 1'b0);
		add_point(32'h8000_0000, 1'b0, 32'h7FFF_FFFF, 20'd0, 1'b0);
		add_point(32'h0000_0000, 1'b1, 32'h8000_0000, 20'd1, 1'b1);
		// saturation both ways, range end clipped to grid
		add_write(fpsm_pkg::REG_COEF_CENTER, 32'h8000_0000);
		add_write(fpsm_pkg::REG_COEF_HORIZONTAL, 32'h7FFF_FFFF);
		add_write(fpsm_pkg::REG_COEF_VERTICAL, 32'h8000_0000);
		add_write(fpsm_pkg::REG_RANGE_FIRST, 32'd0);
		add_write(fpsm_pkg::REG_RANGE_LAST, 32'h000F_FFFF);
		add_item(32'h8000_0000, 1'b0);
		add_point(32'h0000_0000, 1'b0, 32'h7FFF_FFFF, 20'd0, 1'b0);
		add_point(32'h5A5A_5A5A, 1'b1, 32'h7FFF_FFFF, 20'd1, 1'b1);
		add_item(32'h7FFF_FFFF, 1'b0);
		add_point(32'h0000_0000, 1'b0, 32'h8000_0000, 20'd0, 1'b0);
		add_point(32'hFFFF_FFFF, 1'b1, 32'h8000_0000, 20'd1, 1'b1);
		// zero sizes clamp to one point, rounding of halves
		add_write(fpsm_pkg::REG_COEF_CENTER, 32'h0000_8000);
		add_write(fpsm_pkg::REG_COEF_HORIZONTAL, 32'd0);
		add_write(fpsm_pkg::REG_COEF_VERTICAL, 32'd0);
		add_write(fpsm_pkg::REG_GRID_WIDTH, 32'd0);
		add_write(fpsm_pkg::REG_GRID_HEIGHT, 32'd0);
		add_item(32'h0000_0001, 1'b0);
		add_point(32'h0000_0000, 1'b1, 32'h0000_0001, 20'd0, 1'b1);
		add_item(32'hFFFF_FFFF, 1'b0);
		add_point(32'h0000_0000, 1'b1, 32'h0000_0000, 20'd0, 1'b1);
		// 3x3 with all neighbours, flush inside the grid, sample in the drain
		add_write(fpsm_pkg::REG_COEF_CENTER, 32'h0001_8000);
		add_write(fpsm_pkg::REG_COEF_HORIZONTAL, 32'hFFFF_C000);
		add_write(fpsm_pkg::REG_COEF_VERTICAL, 32'h0000_4000);
		add_write(fpsm_pkg::REG_GRID_WIDTH, 32'd3);
		add_write(fpsm_pkg::REG_GRID_HEIGHT, 32'd3);
		add_write(fpsm_pkg::REG_RANGE_FIRST, 32'd2);
		add_write(fpsm_pkg::REG_RANGE_LAST, 32'd6);
		add_item(32'h0001_0000, 1'b0);
		add_item(32'hFFFE_0000, 1'b0);
		add_item(32'h0003_0000, 1'b0);
		add_item(32'h7FFF_FFFF, 1'b0);
		add_item(32'h1111_1111, 1'b1);
		add_item(32'h8000_0000, 1'b0);
		add_item(32'h0000_0001, 1'b0);
		add_item(32'hFFFF_FFFF, 1'b0);
		add_item(32'h0005_0000, 1'b0);
		add_item(32'h0000_0000, 1'b1);
		add_item(32'h1234_5678, 1'b0);
		add_item(32'h0000_0000, 1'b1);
	endfunction

	initial begin
		points_out.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			int stall;
			stall = draw_wait();
			if (stall > 0) begin
				points_out.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			points_out.ready <= 1'b1;
			do @(posedge clk); while (!points_out.valid);
		end
	end

	always @(posedge clk) begin
		point_result_t want;
		if (arst_n && points_out.valid && points_out.ready) begin
			if (expected_points.size() == 0) begin
				$error("unexpected result: result %h point_index %0d last %b",
					points_out.result, points_out.point_index, points_out.last);
				mismatches++;
			end else begin
				want = expected_points.pop_front();
				if (points_out.result !== want.value) begin
					$error("result: expected %h, got %h", want.value, points_out.result);
					mismatches++;
				end
				if (points_out.point_index !== want.index) begin
					$error("point_index: expected %0d, got %0d", want.index,
						points_out.point_index);
					mismatches++;
				end
				if (points_out.last !== want.last) begin
					$error("last: expected %b, got %b", want.last, points_out.last);
					mismatches++;
				end
			end
		end
	end

	initial begin
		bit            hit;
		point_result_t got;
		int unsigned   random_start;
		arst_n <= 1'b0;
		grid_in.valid <= 1'b0;
		grid_in.sample <= '0;
		grid_in.flush <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= fpsm_pkg::REG_COEF_CENTER;
		cfg_data <= '0;
		repeat (WINDOW_LEN) grid_window.push_back(0);
		build_directed();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				if (i == 0 || directed_rows[i - 1].kind != ROW_WRITE) settle();
				write_reg(directed_rows[i].target, directed_rows[i].data);
			end else begin
				transfer_in(directed_rows[i].data, directed_rows[i].flush, hit, got);
				if (directed_rows[i].typed) expected_points.push_back(directed_rows[i].want);
				else if (hit) expected_points.push_back(got);
			end
		end

		random_start = fed_items;
		while (fed_items - random_start < RANDOM_ITEMS) begin
			random_setup();
			repeat ($urandom_range(1, 3)) stream_grid(0, frame_len());
			if ($urandom_range(0, 5) == 0) begin
				// cut a frame short and resize it mid-way
				stream_grid(0, $urandom_range(1, frame_len() - 1));
				settle();
				write_reg(fpsm_pkg::REG_GRID_WIDTH, $urandom_range(0, 12));
				while (frame_count != 0) feed(pick_value(), $urandom_range(0, 3) == 0);
			end
		end

		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_points.size() == 0)
			$display("** five_point_stencil_matvec: PASSED **");
		else
			$display("** five_point_stencil_matvec: FAILED **");
		$finish;
	end

endmodule
